FILE: sv/two_class_priority_server_dispatch_defines.svh
// Assertion macros for the two-class priority server dispatcher.
// Included by tcpsd_datapath, the RTL file that carries concurrent assertions; no dependencies.
`ifndef TWO_CLASS_PRIORITY_SERVER_DISPATCH_DEFINES_SVH
`define TWO_CLASS_PRIORITY_SERVER_DISPATCH_DEFINES_SVH
`ifndef SYNTH
`define TCPSD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("tcpsd: assertion failed");
`define TCPSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tcpsd: assertion failed");
`else
`define TCPSD_ASSERT(lbl, clk, rstn, prop)
`define TCPSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: sv/tcpsd_pkg.sv
// Package for the two-class priority server dispatcher: sizes, codes and the
// controller command struct. No dependencies.
package tcpsd_pkg;

    localparam int QUEUE_DEPTH = 256;
    localparam int NUM_SERVERS = 4;

    localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int SRV_W    = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int ID_W     = 8;
    localparam int LEN_W    = 9;
    localparam int SIDX_W   = 2;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    typedef enum logic {
        CMD_ARRIVE = 1'b0,
        CMD_DEPART = 1'b1
    } cmd_t;

    typedef enum logic {
        CLS_ECONOMY  = 1'b0,
        CLS_BUSINESS = 1'b1
    } class_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_DROPPED = 2'd1,
        STATUS_UNKNOWN = 2'd2
    } status_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } ctrl_cmd_t;

endpackage

FILE: sv/two_class_priority_server_dispatch.sv
// Top level of the two-class priority server dispatcher.
// Instantiates tcpsd_ctrl and tcpsd_datapath; depends on tcpsd_pkg.
//
// Each input transfer is one event (arrive or depart) and yields exactly one
// result transfer. An event is handled in a capture step and a commit step:
// in the first the event is registered while the head entries of both ring
// memories are read out, in the second the queues and the server table are
// updated and the result register is loaded. The second step waits while an
// earlier result is still held on the output, and the next event is taken
// while the current result waits. Reset needs no clearing pass.
module two_class_priority_server_dispatch (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // requester_id [7:0], requester_class [8], zero [15:9]
    input  logic [tcpsd_pkg::S_TDATA_W-1:0] s_tdata,
    // command [0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // dispatched_id [7:0], dispatched_class [8], server_index [10:9],
    // economy_length [19:11], business_length [28:20], status [30:29], zero [31]
    output logic [tcpsd_pkg::M_TDATA_W-1:0] m_tdata,
    // dispatched [0]
    output logic                            m_tuser
);
    import tcpsd_pkg::*;

    ctrl_cmd_t ctrl;

    tcpsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    tcpsd_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

FILE: sv/tcpsd_datapath.sv
// Datapath of the dispatcher: the two ring memories, queue pointers, server
// table and result register. Depends on tcpsd_pkg and the defines header.
`include "two_class_priority_server_dispatch_defines.svh"

module tcpsd_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  tcpsd_pkg::ctrl_cmd_t            ctrl,
    input  logic [tcpsd_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                            s_tuser,
    output logic [tcpsd_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                            m_tuser
);
    import tcpsd_pkg::*;

    logic [ID_W-1:0]  economy_ring  [QUEUE_DEPTH];
    logic [ID_W-1:0]  business_ring [QUEUE_DEPTH];
    logic [ID_W-1:0]  erd_reg, brd_reg;

    logic [ID_W-1:0]  id_reg;
    class_t           cls_reg;
    cmd_t             cmd_reg;

    logic [PTR_W-1:0] ehead_reg, bhead_reg, ehead_next, bhead_next;
    logic [CNT_W-1:0] ecnt_reg, bcnt_reg, ecnt_next, bcnt_next;
    logic [NUM_SERVERS-1:0] busy_reg, busy_next;
    logic [ID_W-1:0]  holder_reg [NUM_SERVERS];

    logic             is_arrive, is_bus, push_ok, found, any_free, take, take_bus;
    logic [CNT_W-1:0] push_cnt, ecnt_mid, bcnt_mid;
    logic [PTR_W-1:0] push_head, wr_addr;
    logic [CNT_W:0]   slot_sum;
    logic [NUM_SERVERS-1:0] match, busy_mid, busy_set;
    logic [SRV_W-1:0] free_idx;
    logic [ID_W-1:0]  taken_id;
    status_t          status;

    logic             disp_reg;
    logic [ID_W-1:0]  did_reg;
    logic             dcls_reg;
    logic [SIDX_W-1:0] sidx_reg;
    logic [LEN_W-1:0] elen_reg, blen_reg;
    status_t          status_reg;

    always_comb begin
        is_arrive = (cmd_reg == CMD_ARRIVE);
        is_bus    = (cls_reg == CLS_BUSINESS);
        push_cnt  = is_bus ? bcnt_reg : ecnt_reg;
        push_head = is_bus ? bhead_reg : ehead_reg;
        push_ok   = is_arrive && (push_cnt != CNT_W'(QUEUE_DEPTH));
        slot_sum  = (CNT_W+1)'(push_head) + (CNT_W+1)'(push_cnt);
        if (slot_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
            wr_addr = PTR_W'(slot_sum - (CNT_W+1)'(QUEUE_DEPTH));
        end else begin
            wr_addr = PTR_W'(slot_sum);
        end

        for (int i = 0; i < NUM_SERVERS; i++) begin
            match[i] = !is_arrive && busy_reg[i] && (holder_reg[i] == id_reg);
        end
        found    = |match;
        busy_mid = busy_reg & ~match;

        ecnt_mid = ecnt_reg + CNT_W'(push_ok && !is_bus);
        bcnt_mid = bcnt_reg + CNT_W'(push_ok && is_bus);

        any_free = 1'b0;
        free_idx = '0;
        for (int i = NUM_SERVERS - 1; i >= 0; i--) begin
            if (!busy_mid[i]) begin
                any_free = 1'b1;
                free_idx = SRV_W'(i);
            end
        end

        take_bus = (bcnt_mid != '0);
        take     = any_free && (take_bus || (ecnt_mid != '0));
        // An entry pushed into an empty queue this step is taken straight from the input.
        if (take_bus) begin
            taken_id = (bcnt_reg == '0) ? id_reg : brd_reg;
        end else begin
            taken_id = (ecnt_reg == '0) ? id_reg : erd_reg;
        end

        ecnt_next  = ecnt_mid - CNT_W'(take && !take_bus);
        bcnt_next  = bcnt_mid - CNT_W'(take && take_bus);
        ehead_next = ehead_reg;
        bhead_next = bhead_reg;
        if (take && take_bus) begin
            bhead_next = (bhead_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : bhead_reg + 1'b1;
        end
        if (take && !take_bus) begin
            ehead_next = (ehead_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ehead_reg + 1'b1;
        end
        busy_set  = take ? (NUM_SERVERS'(1) << free_idx) : '0;
        busy_next = busy_mid | busy_set;

        if (is_arrive && !push_ok) begin
            status = STATUS_DROPPED;
        end else if (!is_arrive && !found) begin
            status = STATUS_UNKNOWN;
        end else begin
            status = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.commit && push_ok && !is_bus) begin
            economy_ring[wr_addr] <= id_reg;
        end
        erd_reg <= economy_ring[ehead_reg];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.commit && push_ok && is_bus) begin
            business_ring[wr_addr] <= id_reg;
        end
        brd_reg <= business_ring[bhead_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ehead_reg <= '0;
            bhead_reg <= '0;
            ecnt_reg  <= '0;
            bcnt_reg  <= '0;
            busy_reg  <= '0;
        end else if (ctrl.commit) begin
            ehead_reg <= ehead_next;
            bhead_reg <= bhead_next;
            ecnt_reg  <= ecnt_next;
            bcnt_reg  <= bcnt_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            id_reg  <= s_tdata[ID_W-1:0];
            cls_reg <= class_t'(s_tdata[ID_W]);
            cmd_reg <= cmd_t'(s_tuser);
        end
        if (ctrl.commit && take) begin
            holder_reg[free_idx] <= taken_id;
        end
        if (ctrl.commit) begin
            disp_reg   <= take;
            did_reg    <= take ? taken_id : '0;
            dcls_reg   <= take && take_bus;
            sidx_reg   <= take ? SIDX_W'(free_idx) : '0;
            elen_reg   <= LEN_W'(ecnt_next);
            blen_reg   <= LEN_W'(bcnt_next);
            status_reg <= status;
        end
    end

    assign m_tdata = {1'b0, status_reg, blen_reg, elen_reg, sidx_reg, dcls_reg, did_reg};
    assign m_tuser = disp_reg;

    `TCPSD_ASSERT(a_count_bound, aclk, aresetn, (ecnt_reg <= CNT_W'(QUEUE_DEPTH)) && (bcnt_reg <= CNT_W'(QUEUE_DEPTH)))
    `TCPSD_ASSERT_NEXT(a_taken_server_busy, aclk, aresetn, ctrl.commit && take, busy_reg[$past(free_idx)])
    `TCPSD_ASSERT_NEXT(a_one_grant, aclk, aresetn, ctrl.commit, $countones(busy_reg) <= $countones($past(busy_reg)) + 1)

endmodule

FILE: sv/tcpsd_ctrl.sv
// Controller of the dispatcher: sequences capture and commit of each event
// and holds the result valid flag. Depends on tcpsd_pkg.
module tcpsd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output tcpsd_pkg::ctrl_cmd_t ctrl
);
    import tcpsd_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        s_tready     = (state_reg == S_IDLE);
        ctrl.capture = s_tvalid && (state_reg == S_IDLE);
        ctrl.commit  = (state_reg == S_EXEC) && (!m_valid_reg || m_tready);
        state_next   = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (ctrl.capture) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (ctrl.commit) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (ctrl.commit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for two_class_priority_server_dispatch: stream driver and
// monitor, a queue-and-server predictor of the dispatcher, and phased idling.
// Depends on tcpsd_pkg and the top level of the block.
module tb_top;
    import tcpsd_pkg::*;

    localparam int LONG_HOLD = 300;

    typedef struct {
        cmd_t             cmd;
        logic [ID_W-1:0]  id;
        class_t           cls;
    } req_t;

    typedef struct {
        logic              dispatched;
        logic [ID_W-1:0]   id;
        class_t            cls;
        logic [SIDX_W-1:0] server;
        logic [LEN_W-1:0]  econ_len;
        logic [LEN_W-1:0]  bus_len;
        status_t           status;
    } grant_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    req_t   pending_reqs[$];
    grant_t expected_grants[$];
    req_t   on_bus;

    logic [ID_W-1:0] economy_line[$];
    logic [ID_W-1:0] business_line[$];
    bit              desk_busy[NUM_SERVERS];
    logic [ID_W-1:0] desk_holder[NUM_SERVERS];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int mismatches = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_dispatched = 0;
    int n_business = 0;
    int n_dropped = 0;
    int n_unknown = 0;
    int peak_economy = 0;
    int peak_business = 0;

    two_class_priority_server_dispatch dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic serve_event(input req_t r);
        grant_t g;
        int     free_desk;
        bit     found;
        g.dispatched = 1'b0;
        g.id = '0;
        g.cls = CLS_ECONOMY;
        g.server = '0;
        g.status = STATUS_OK;
        found = 1'b0;
        free_desk = -1;
        if (r.cmd == CMD_ARRIVE) begin
            if (r.cls == CLS_BUSINESS) begin
                if (business_line.size() >= QUEUE_DEPTH) g.status = STATUS_DROPPED;
                else business_line.push_back(r.id);
            end else begin
                if (economy_line.size() >= QUEUE_DEPTH) g.status = STATUS_DROPPED;
                else economy_line.push_back(r.id);
            end
        end else begin
            for (int i = 0; i < NUM_SERVERS; i++) begin
                if (desk_busy[i] && desk_holder[i] == r.id) begin
                    desk_busy[i] = 1'b0;
                    desk_holder[i] = '0;
                    found = 1'b1;
                end
            end
            if (!found) g.status = STATUS_UNKNOWN;
        end
        for (int i = NUM_SERVERS - 1; i >= 0; i--) begin
            if (!desk_busy[i]) free_desk = i;
        end
        if (economy_line.size() > peak_economy) peak_economy = economy_line.size();
        if (business_line.size() > peak_business) peak_business = business_line.size();
        if (free_desk >= 0 && (business_line.size() != 0 || economy_line.size() != 0)) begin
            if (business_line.size() != 0) begin
                g.id = business_line.pop_front();
                g.cls = CLS_BUSINESS;
            end else begin
                g.id = economy_line.pop_front();
                g.cls = CLS_ECONOMY;
            end
            desk_busy[free_desk] = 1'b1;
            desk_holder[free_desk] = g.id;
            g.dispatched = 1'b1;
            g.server = free_desk[SIDX_W-1:0];
        end
        g.econ_len = LEN_W'(economy_line.size());
        g.bus_len = LEN_W'(business_line.size());
        expected_grants.push_back(g);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) serve_event(on_bus);
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {{(S_TDATA_W - ID_W - 1){1'b0}}, on_bus.cls, on_bus.id};
                    s_tuser <= on_bus.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_requests != hold_seen) begin
            hold_seen <= hold_requests;
            hold_left <= LONG_HOLD;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= (hold_left == 0) && (hold_seen == hold_requests) &&
                        ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin : monitor
        grant_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_grants.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got 0x%08h", $time, m_tdata);
            end else begin
                want = expected_grants.pop_front();
                n_checked++;
                if (want.dispatched) n_dispatched++;
                if (want.dispatched && want.cls == CLS_BUSINESS) n_business++;
                if (want.status == STATUS_DROPPED) n_dropped++;
                if (want.status == STATUS_UNKNOWN) n_unknown++;
                check_field("dispatched", 32'(want.dispatched), 32'(m_tuser));
                check_field("dispatched_id", 32'(want.id), 32'(m_tdata[7:0]));
                check_field("dispatched_class", 32'(want.cls), 32'(m_tdata[8]));
                check_field("server_index", 32'(want.server), 32'(m_tdata[10:9]));
                check_field("economy_length", 32'(want.econ_len), 32'(m_tdata[19:11]));
                check_field("business_length", 32'(want.bus_len), 32'(m_tdata[28:20]));
                check_field("status", 32'(want.status), 32'(m_tdata[30:29]));
            end
        end
    end

    task automatic offer(input cmd_t cmd, input logic [ID_W-1:0] id, input class_t cls);
        req_t r;
        r.cmd = cmd;
        r.id = id;
        r.cls = cls;
        while (pending_reqs.size() >= 2) @(negedge aclk);
        pending_reqs.push_back(r);
        n_sent++;
    endtask

    function automatic logic [ID_W-1:0] departing_id(input bit known);
        int busy_list[$];
        for (int i = 0; i < NUM_SERVERS; i++) begin
            if (desk_busy[i]) busy_list.push_back(i);
        end
        if (known && busy_list.size() != 0)
            return desk_holder[busy_list[$urandom_range(busy_list.size() - 1)]];
        return ID_W'($urandom_range(255));
    endfunction

    task automatic wait_quiet();
        while (pending_reqs.size() != 0 || s_tvalid || expected_grants.size() != 0)
            @(negedge aclk);
    endtask

    task automatic mixed_traffic(input int count);
        int               pick;
        logic [ID_W-1:0]  id;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            id = $urandom_range(1) ? ID_W'($urandom_range(255)) : ID_W'($urandom_range(7));
            if (pick < 45)
                offer(CMD_ARRIVE, id, class_t'($urandom_range(1)));
            else if (pick < 85)
                offer(CMD_DEPART, departing_id(1'b1), class_t'($urandom_range(1)));
            else
                offer(CMD_DEPART, id, class_t'($urandom_range(1)));
        end
    endtask

    task automatic fill_and_drain(input class_t target);
        int need;
        int done;
        int guard;
        need = NUM_SERVERS + 3 + $urandom_range(3) +
               QUEUE_DEPTH - ((target == CLS_BUSINESS) ? business_line.size()
                                                       : economy_line.size());
        done = 0;
        while (done < need) begin
            if ($urandom_range(7) == 0) begin
                offer(CMD_ARRIVE, ID_W'($urandom_range(255)), class_t'(~target));
            end else begin
                offer(CMD_ARRIVE, ID_W'($urandom_range(255)), target);
                done++;
            end
        end
        guard = 0;
        while (guard < 2 * QUEUE_DEPTH + 40) begin
            while (pending_reqs.size() != 0 || s_tvalid) @(negedge aclk);
            if (economy_line.size() + business_line.size() == 0) break;
            offer(CMD_DEPART, departing_id($urandom_range(9) != 0), class_t'($urandom_range(1)));
            guard++;
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        offer(CMD_ARRIVE, 8'h00, CLS_ECONOMY);
        offer(CMD_ARRIVE, 8'hFF, CLS_BUSINESS);
        offer(CMD_ARRIVE, 8'h00, CLS_ECONOMY);
        offer(CMD_DEPART, 8'h00, CLS_ECONOMY);
        offer(CMD_DEPART, 8'h42, CLS_ECONOMY);
        offer(CMD_DEPART, 8'hFF, CLS_BUSINESS);
        offer(CMD_ARRIVE, 8'h01, CLS_ECONOMY);
        offer(CMD_ARRIVE, 8'h02, CLS_ECONOMY);
        offer(CMD_ARRIVE, 8'h03, CLS_ECONOMY);
        offer(CMD_ARRIVE, 8'h04, CLS_ECONOMY);
        offer(CMD_ARRIVE, 8'h10, CLS_ECONOMY);
        offer(CMD_ARRIVE, 8'h11, CLS_ECONOMY);
        offer(CMD_ARRIVE, 8'h20, CLS_BUSINESS);
        offer(CMD_ARRIVE, 8'h21, CLS_BUSINESS);
        offer(CMD_DEPART, 8'h02, CLS_ECONOMY);
        offer(CMD_DEPART, 8'h99, CLS_BUSINESS);
        offer(CMD_DEPART, 8'h01, CLS_ECONOMY);
        offer(CMD_DEPART, 8'h03, CLS_ECONOMY);
        offer(CMD_DEPART, 8'h20, CLS_ECONOMY);
        offer(CMD_DEPART, 8'h04, CLS_ECONOMY);
        offer(CMD_DEPART, 8'h21, CLS_ECONOMY);
        offer(CMD_DEPART, 8'h10, CLS_ECONOMY);
        offer(CMD_DEPART, 8'h11, CLS_ECONOMY);
        wait_quiet();

        for (int ph = 0; ph < 4; ph++) begin
            @(negedge aclk);
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 49 : 28) : 0;
            recv_stall_pct = (ph == 2) ? 49 : ((ph == 3) ? 28 : 0);
            case (ph)
                0: begin
                    mixed_traffic(100);
                    @(negedge aclk);
                    hold_requests++;
                    mixed_traffic(100);
                    fill_and_drain(CLS_ECONOMY);
                end
                2: begin
                    fill_and_drain(CLS_BUSINESS);
                    mixed_traffic(50);
                end
                default: begin
                    mixed_traffic(200);
                end
            endcase
            wait_quiet();
        end

        repeat (20) @(posedge aclk);
        $display("Sent %0d events, checked %0d results: %0d dispatches (%0d business).",
                 n_sent, n_checked, n_dispatched, n_business);
        $display("Drops on a full queue %0d, unknown departures %0d, peak lengths %0d / %0d.",
                 n_dropped, n_unknown, peak_economy, peak_business);
        if (mismatches == 0 && expected_grants.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d results outstanding.", expected_grants.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/tcpsd_pkg.sv
sv/tcpsd_datapath.sv
sv/tcpsd_ctrl.sv
sv/two_class_priority_server_dispatch.sv
sim/tb_top.sv
